/* hdl/zmp_pkg.sv */
package zmp_pkg;

  // Default sizes of the preview gain table and the reference queue.
  localparam int PREVIEW_LEN_DEF = 256;
  localparam int QUEUE_DEPTH_DEF = 256;

  // Port widths.
  localparam int WORD_W     = 64;
  localparam int IN_DATA_W  = 584;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 400;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int LEVEL_W    = 9;

  // Reset values of the Q0.32 timing registers.
  localparam logic [31:0] DT_RST   = 32'd42949673;
  localparam logic [31:0] DT2H_RST = 32'd214748;
  localparam logic [31:0] DT3S_RST = 32'd716;
  localparam logic [31:0] HOG_RST  = 32'd87563216;

  localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_STEP  = 3'd1,
    CMD_INIT  = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_GAIN  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_READY = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_KI   = 3'd0,
    CFG_KPOS = 3'd1,
    CFG_KVEL = 3'd2,
    CFG_KACC = 3'd3,
    CFG_DT   = 3'd4,
    CFG_DT2H = 3'd5,
    CFG_DT3S = 3'd6,
    CFG_HOG  = 3'd7
  } cfg_idx_t;

  // Where a finished product goes.
  typedef enum logic [2:0] {
    TAG_U   = 3'd0,
    TAG_X0  = 3'd1,
    TAG_X1  = 3'd2,
    TAG_X2  = 3'd3,
    TAG_ZMP = 3'd4
  } tag_t;

  typedef struct packed {
    logic valid;
    tag_t tag;
  } mul_ctl_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_FEED,
    ST_TAP,
    ST_WAIT_U,
    ST_UPD,
    ST_WAIT_X,
    ST_ZMP,
    ST_WAIT_Z,
    ST_ERR,
    ST_ERR2,
    ST_DONE
  } state_t;

  // Saturating signed add.
  function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      r = a[63] ? SMIN : SMAX;
    end
    return r;
  endfunction

  // Saturating signed subtract.
  function automatic logic [63:0] ssub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) begin
      r = a[63] ? SMIN : SMAX;
    end
    return r;
  endfunction

endpackage

/* hdl/zmp_ram.sv */
module zmp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/zmp_qmul.sv */
module zmp_qmul (
  input  logic               clk,
  input  logic               rst,
  input  zmp_pkg::mul_ctl_t  in_ctl,
  input  logic [63:0]        in_a,
  input  logic [63:0]        in_b,
  output zmp_pkg::mul_ctl_t  out_ctl,
  output logic [63:0]        out_p
);

  // Six stages: magnitudes, partial products, two summing stages,
  // sign restore, then rounding and saturation.
  zmp_pkg::mul_ctl_t ctl_q [6];

  logic         neg1, neg2, neg3, neg4;
  logic [63:0]  ma1, mb1;
  logic [63:0]  ll2, lh2, hl2, hh2;
  logic [33:0]  mid3;
  logic [31:0]  lo3;
  logic [63:0]  hs3;
  logic [127:0] mag4;
  logic [127:0] v5;
  logic [127:0] rnd;

  // Control travels alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        ctl_q[i] <= '0;
      end
    end else begin
      ctl_q[0] <= in_ctl;
      for (int i = 1; i < 6; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  assign rnd = v5 + 128'h8000_0000;

  always_ff @(posedge clk) begin
    neg1 <= in_a[63] ^ in_b[63];
    ma1  <= in_a[63] ? (64'd0 - in_a) : in_a;
    mb1  <= in_b[63] ? (64'd0 - in_b) : in_b;

    neg2 <= neg1;
    ll2  <= ma1[31:0] * mb1[31:0];
    lh2  <= ma1[31:0] * mb1[63:32];
    hl2  <= ma1[63:32] * mb1[31:0];
    hh2  <= ma1[63:32] * mb1[63:32];

    neg3 <= neg2;
    mid3 <= 34'(ll2[63:32]) + 34'(lh2[31:0]) + 34'(hl2[31:0]);
    lo3  <= ll2[31:0];
    hs3  <= hh2 + 64'(lh2[63:32]) + 64'(hl2[63:32]);

    neg4 <= neg3;
    mag4 <= {hs3 + 64'(mid3[33:32]), mid3[31:0], lo3};

    v5 <= neg4 ? (128'd0 - mag4) : mag4;

    // Round half up, then clamp when the upper word is not a sign extension.
    if (rnd[127:96] != {32{rnd[95]}}) begin
      out_p <= rnd[127] ? zmp_pkg::SMIN : zmp_pkg::SMAX;
    end else begin
      out_p <= rnd[95:32];
    end
  end

  assign out_ctl = ctl_q[5];

endmodule

/* hdl/zmp_preview_controller_core.sv */
// Sequencing: push, init, clear, gain load, unknown and refused commands pass from
// acceptance through ST_DONE to the result register; a step runs each axis through its
// phases, one product per cycle through the shared six-stage multiplier, pausing for it to drain between phases.
// Throughput: one item at a time; s_tready returns the cycle the result is shown.
// Reset (synchronous, rst high) clears control and state, then sweeps the gain memory
// to zero in ST_CLR with s_tready low; queue contents stay undefined.
module zmp_preview_controller_core #(
  parameter int PREVIEW_LEN = zmp_pkg::PREVIEW_LEN_DEF,
  parameter int QUEUE_DEPTH = zmp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [zmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [zmp_pkg::WORD_W-1:0]    cfg_data,
  // Input items.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // ref_x, ref_y, init_pos_x, init_vel_x, init_acc_x, init_pos_y, init_vel_y,
  // init_acc_y, gain_index, gain_value
  input  logic [zmp_pkg::IN_DATA_W-1:0] s_tdata,
  // cmd
  input  logic [zmp_pkg::IN_USER_W-1:0] s_tuser,
  // Result items.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // com_pos_x, com_vel_x, com_acc_x, com_pos_y, com_vel_y, com_acc_y,
  // queue_level, zero fill
  output logic [zmp_pkg::OUT_DATA_W-1:0] m_tdata,
  // status
  output logic [zmp_pkg::OUT_USER_W-1:0] m_tuser
);

  localparam int QA = $clog2(QUEUE_DEPTH);
  localparam int GA = $clog2(PREVIEW_LEN);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = $clog2(PREVIEW_LEN + 1);

  // Input fields.
  logic [63:0] ref_x, ref_y, init_pos_x, init_vel_x, init_acc_x;
  logic [63:0] init_pos_y, init_vel_y, init_acc_y, gain_value;
  logic [7:0]  gain_index;
  zmp_pkg::cmd_t cmd;

  assign ref_x      = s_tdata[63:0];
  assign ref_y      = s_tdata[127:64];
  assign init_pos_x = s_tdata[191:128];
  assign init_vel_x = s_tdata[255:192];
  assign init_acc_x = s_tdata[319:256];
  assign init_pos_y = s_tdata[383:320];
  assign init_vel_y = s_tdata[447:384];
  assign init_acc_y = s_tdata[511:448];
  assign gain_index = s_tdata[519:512];
  assign gain_value = s_tdata[583:520];
  assign cmd        = zmp_pkg::cmd_t'(s_tuser[2:0]);

  // Configuration registers.
  logic [63:0] ki, k_pos, k_vel, k_acc;
  logic [31:0] dt, dt2h, dt3s, hog;

  always_ff @(posedge clk) begin
    if (rst) begin
      ki    <= '0;
      k_pos <= '0;
      k_vel <= '0;
      k_acc <= '0;
      dt    <= zmp_pkg::DT_RST;
      dt2h  <= zmp_pkg::DT2H_RST;
      dt3s  <= zmp_pkg::DT3S_RST;
      hog   <= zmp_pkg::HOG_RST;
    end else if (cfg_we) begin
      unique case (zmp_pkg::cfg_idx_t'(cfg_index))
        zmp_pkg::CFG_KI:   ki    <= cfg_data;
        zmp_pkg::CFG_KPOS: k_pos <= cfg_data;
        zmp_pkg::CFG_KVEL: k_vel <= cfg_data;
        zmp_pkg::CFG_KACC: k_acc <= cfg_data;
        zmp_pkg::CFG_DT:   dt    <= cfg_data[31:0];
        zmp_pkg::CFG_DT2H: dt2h  <= cfg_data[31:0];
        zmp_pkg::CFG_DT3S: dt3s  <= cfg_data[31:0];
        zmp_pkg::CFG_HOG:  hog   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Control and state registers.
  zmp_pkg::state_t  state, state_next;
  zmp_pkg::status_t stat;
  logic             ax;
  logic [2:0]       j;
  logic [TW-1:0]    ti, taps;
  logic [QA-1:0]    qptr, head;
  logic [CW-1:0]    count;
  logic [3:0]       pend;
  logic             rd_v, rd_first;
  logic [GA-1:0]    clr_i;
  logic [63:0]      x_pos, x_vel, x_acc, y_pos, y_vel, y_acc, err_x, err_y;

  // Step datapath registers.
  logic [63:0] u_acc, nx0, nx1, nx2, zmp, front, dz;

  // Memory ports.
  logic              g_we, q_we;
  logic [GA-1:0]     g_waddr, g_raddr;
  logic [63:0]       g_wdata, g_rdata;
  logic [QA-1:0]     q_waddr;
  logic [127:0]      q_wdata, q_rdata;

  // Multiplier ports.
  zmp_pkg::mul_ctl_t mi_ctl, mo_ctl;
  logic [63:0]       mi_a, mi_b, mo_p;

  // Current axis view.
  logic [63:0] cur_pos, cur_vel, cur_acc, cur_err;
  assign cur_pos = ax ? y_pos : x_pos;
  assign cur_vel = ax ? y_vel : x_vel;
  assign cur_acc = ax ? y_acc : x_acc;
  assign cur_err = ax ? err_y : err_x;

  // Queue index helpers.
  function automatic logic [QA-1:0] qwrap(input logic [QA:0] s);
    logic [QA:0] r;
    r = (s >= (QA+1)'(QUEUE_DEPTH)) ? s - (QA+1)'(QUEUE_DEPTH) : s;
    return r[QA-1:0];
  endfunction

  function automatic logic [QA-1:0] qinc(input logic [QA-1:0] p);
    return (p == QA'(QUEUE_DEPTH - 1)) ? '0 : p + QA'(1);
  endfunction

  logic          acc;
  logic [31:0]   cnt32, idx32;
  logic          q_full, step_ok, gain_ok, drained;
  logic [TW-1:0] taps_calc;
  logic [QA-1:0] push_slot;

  assign s_tready  = (state == zmp_pkg::ST_IDLE);
  assign acc       = s_tvalid && s_tready;
  assign cnt32     = 32'(count);
  assign idx32     = 32'(gain_index);
  assign q_full    = (cnt32 == QUEUE_DEPTH);
  assign step_ok   = !(cnt32 < PREVIEW_LEN - 1 || cnt32 == 0);
  assign gain_ok   = (idx32 < PREVIEW_LEN);
  assign taps_calc = (cnt32 < PREVIEW_LEN) ? TW'(count) : TW'(PREVIEW_LEN);
  assign push_slot = qwrap({1'b0, head} + (QA+1)'(count));
  assign drained   = (pend == 4'd0) && !rd_v;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      zmp_pkg::ST_CLR:    if (32'(clr_i) == PREVIEW_LEN - 1) state_next = zmp_pkg::ST_IDLE;
      zmp_pkg::ST_IDLE: begin
        if (acc) begin
          state_next = (cmd == zmp_pkg::CMD_STEP && step_ok) ? zmp_pkg::ST_FEED
                                                              : zmp_pkg::ST_DONE;
        end
      end
      zmp_pkg::ST_FEED:   if (j == 3'd3) state_next = zmp_pkg::ST_TAP;
      zmp_pkg::ST_TAP:    if (ti == taps - TW'(1)) state_next = zmp_pkg::ST_WAIT_U;
      zmp_pkg::ST_WAIT_U: if (drained) state_next = zmp_pkg::ST_UPD;
      zmp_pkg::ST_UPD:    if (j == 3'd5) state_next = zmp_pkg::ST_WAIT_X;
      zmp_pkg::ST_WAIT_X: if (drained) state_next = zmp_pkg::ST_ZMP;
      zmp_pkg::ST_ZMP:    state_next = zmp_pkg::ST_WAIT_Z;
      zmp_pkg::ST_WAIT_Z: if (drained) state_next = zmp_pkg::ST_ERR;
      zmp_pkg::ST_ERR:    state_next = zmp_pkg::ST_ERR2;
      zmp_pkg::ST_ERR2:   state_next = ax ? zmp_pkg::ST_DONE : zmp_pkg::ST_FEED;
      zmp_pkg::ST_DONE:   if (!m_tvalid || m_tready) state_next = zmp_pkg::ST_IDLE;
      default:            state_next = zmp_pkg::ST_IDLE;
    endcase
  end

  // Multiplier issue and memory port control.
  always_comb begin
    mi_ctl  = '0;
    mi_a    = '0;
    mi_b    = '0;
    g_we    = 1'b0;
    g_waddr = '0;
    g_wdata = '0;
    q_we    = 1'b0;
    q_waddr = push_slot;
    q_wdata = {ref_y, ref_x};
    g_raddr = ti[GA-1:0];

    if (rd_v) begin
      // Preview tap: gain times queued reference of the current axis.
      mi_ctl = '{valid: 1'b1, tag: zmp_pkg::TAG_U};
      mi_a   = g_rdata;
      mi_b   = ax ? q_rdata[127:64] : q_rdata[63:0];
    end

    unique case (state)
      zmp_pkg::ST_CLR: begin
        g_we    = 1'b1;
        g_waddr = clr_i;
      end
      zmp_pkg::ST_IDLE: begin
        if (acc && cmd == zmp_pkg::CMD_GAIN && gain_ok) begin
          g_we    = 1'b1;
          g_waddr = idx32[GA-1:0];
          g_wdata = gain_value;
        end
        if (acc && cmd == zmp_pkg::CMD_PUSH && !q_full) begin
          q_we = 1'b1;
        end
      end
      zmp_pkg::ST_FEED: begin
        mi_ctl = '{valid: 1'b1, tag: zmp_pkg::TAG_U};
        case (j)
          3'd0:    begin mi_a = ki;    mi_b = cur_err; end
          3'd1:    begin mi_a = k_pos; mi_b = cur_pos; end
          3'd2:    begin mi_a = k_vel; mi_b = cur_vel; end
          default: begin mi_a = k_acc; mi_b = cur_acc; end
        endcase
      end
      zmp_pkg::ST_UPD: begin
        case (j)
          3'd0: begin
            mi_ctl = '{valid: 1'b1, tag: zmp_pkg::TAG_X0};
            mi_a = {32'd0, dt};   mi_b = cur_vel;
          end
          3'd1: begin
            mi_ctl = '{valid: 1'b1, tag: zmp_pkg::TAG_X0};
            mi_a = {32'd0, dt2h}; mi_b = cur_acc;
          end
          3'd2: begin
            mi_ctl = '{valid: 1'b1, tag: zmp_pkg::TAG_X0};
            mi_a = {32'd0, dt3s}; mi_b = u_acc;
          end
          3'd3: begin
            mi_ctl = '{valid: 1'b1, tag: zmp_pkg::TAG_X1};
            mi_a = {32'd0, dt};   mi_b = cur_acc;
          end
          3'd4: begin
            mi_ctl = '{valid: 1'b1, tag: zmp_pkg::TAG_X1};
            mi_a = {32'd0, dt2h}; mi_b = u_acc;
          end
          3'd5: begin
            mi_ctl = '{valid: 1'b1, tag: zmp_pkg::TAG_X2};
            mi_a = {32'd0, dt};   mi_b = u_acc;
          end
          default: ;
        endcase
      end
      zmp_pkg::ST_ZMP: begin
        mi_ctl = '{valid: 1'b1, tag: zmp_pkg::TAG_ZMP};
        mi_a   = {32'd0, hog};
        mi_b   = nx2;
      end
      default: ;
    endcase
  end

  // Gain table and reference queue (x in the low word, y in the high word).
  zmp_ram #(.WIDTH(64), .DEPTH(PREVIEW_LEN)) u_gain_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  zmp_ram #(.WIDTH(128), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (qptr),
    .rdata (q_rdata)
  );

  zmp_qmul u_qmul (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (mi_ctl),
    .in_a    (mi_a),
    .in_b    (mi_b),
    .out_ctl (mo_ctl),
    .out_p   (mo_p)
  );

  // Step datapath: products are folded in issue order.
  always_ff @(posedge clk) begin
    if (state_next == zmp_pkg::ST_FEED && state != zmp_pkg::ST_FEED) begin
      u_acc <= '0;
    end
    if (mo_ctl.valid) begin
      case (mo_ctl.tag)
        zmp_pkg::TAG_U:  u_acc <= zmp_pkg::ssub(u_acc, mo_p);
        zmp_pkg::TAG_X0: nx0   <= zmp_pkg::sadd(nx0, mo_p);
        zmp_pkg::TAG_X1: nx1   <= zmp_pkg::sadd(nx1, mo_p);
        zmp_pkg::TAG_X2: nx2   <= zmp_pkg::sadd(nx2, mo_p);
        default:         zmp   <= zmp_pkg::ssub(nx0, mo_p);
      endcase
    end
    if (rd_v && rd_first) begin
      front <= ax ? q_rdata[127:64] : q_rdata[63:0];
    end
    if (state == zmp_pkg::ST_WAIT_U && drained) begin
      nx0 <= cur_pos;
      nx1 <= cur_vel;
      nx2 <= cur_acc;
    end
    if (state == zmp_pkg::ST_ERR) begin
      dz <= zmp_pkg::ssub(zmp, front);
    end
  end

  // Control, queue pointers, axis state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= zmp_pkg::ST_CLR;
      stat     <= zmp_pkg::STAT_OK;
      ax       <= 1'b0;
      j        <= '0;
      ti       <= '0;
      taps     <= '0;
      qptr     <= '0;
      head     <= '0;
      count    <= '0;
      pend     <= '0;
      rd_v     <= 1'b0;
      rd_first <= 1'b0;
      clr_i    <= '0;
      x_pos    <= '0;
      x_vel    <= '0;
      x_acc    <= '0;
      y_pos    <= '0;
      y_vel    <= '0;
      y_acc    <= '0;
      err_x    <= '0;
      err_y    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      pend     <= pend + 4'(mi_ctl.valid) - 4'(mo_ctl.valid);
      rd_v     <= (state == zmp_pkg::ST_TAP);
      rd_first <= (state == zmp_pkg::ST_TAP) && (ti == '0);
      if (m_tvalid && m_tready && state != zmp_pkg::ST_DONE) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        zmp_pkg::ST_CLR: clr_i <= clr_i + GA'(1);
        zmp_pkg::ST_IDLE: begin
          if (acc) begin
            case (cmd)
              zmp_pkg::CMD_PUSH: begin
                if (q_full) begin
                  stat <= zmp_pkg::STAT_FULL;
                end else begin
                  stat  <= zmp_pkg::STAT_OK;
                  count <= count + CW'(1);
                end
              end
              zmp_pkg::CMD_STEP: begin
                if (!step_ok) begin
                  stat <= zmp_pkg::STAT_NOT_READY;
                end else begin
                  stat <= zmp_pkg::STAT_OK;
                  ax   <= 1'b0;
                  j    <= '0;
                  ti   <= '0;
                  qptr <= head;
                  taps <= taps_calc;
                end
              end
              zmp_pkg::CMD_INIT: begin
                stat  <= zmp_pkg::STAT_OK;
                x_pos <= init_pos_x;
                x_vel <= init_vel_x;
                x_acc <= init_acc_x;
                y_pos <= init_pos_y;
                y_vel <= init_vel_y;
                y_acc <= init_acc_y;
              end
              zmp_pkg::CMD_CLEAR: begin
                stat  <= zmp_pkg::STAT_OK;
                head  <= '0;
                count <= '0;
                err_x <= '0;
                err_y <= '0;
              end
              default: stat <= zmp_pkg::STAT_OK;
            endcase
          end
        end
        zmp_pkg::ST_FEED: j <= (j == 3'd3) ? 3'd0 : j + 3'd1;
        zmp_pkg::ST_TAP: begin
          ti   <= ti + TW'(1);
          qptr <= qinc(qptr);
        end
        zmp_pkg::ST_WAIT_U: if (drained) j <= '0;
        zmp_pkg::ST_UPD: j <= j + 3'd1;
        zmp_pkg::ST_ERR2: begin
          if (ax) begin
            y_pos <= nx0;
            y_vel <= nx1;
            y_acc <= nx2;
            err_y <= zmp_pkg::sadd(err_y, dz);
            head  <= qinc(head);
            count <= count - CW'(1);
          end else begin
            x_pos <= nx0;
            x_vel <= nx1;
            x_acc <= nx2;
            err_x <= zmp_pkg::sadd(err_x, dz);
            ax    <= 1'b1;
            j     <= '0;
            ti    <= '0;
            qptr  <= head;
          end
        end
        zmp_pkg::ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, cnt32[zmp_pkg::LEVEL_W-1:0],
                         y_acc, y_vel, y_pos, x_acc, x_vel, x_pos};
            m_tuser  <= stat;
          end
        end
        default: ;
      endcase
    end
  end

  // A product leaves the multiplier only if one was counted in flight.
  a_pend_ok: assert property (@(posedge clk) disable iff (rst)
    mo_ctl.valid |-> pend != 4'd0)
    else $error("multiplier result without a pending issue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt32 <= QUEUE_DEPTH)
    else $error("queue count above depth");

  a_tap_read: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> (state == zmp_pkg::ST_TAP || state == zmp_pkg::ST_WAIT_U))
    else $error("tap read returned outside the tap phase");

  a_pop: assert property (@(posedge clk) disable iff (rst)
    (state == zmp_pkg::ST_ERR2 && ax) |=> count == $past(count) - CW'(1))
    else $error("step did not pop one queue entry");

endmodule
